>>> sv/im2col_pkg.sv
// shared types, constants and field widths for the im2col patch unroller
package im2col_pkg;

  // default geometry of the image store
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int IMAGE_WORDS_DEF = 4096;

  // field widths
  localparam int DIM_W      = 7;
  localparam int KERN_W     = 4;
  localparam int PAD_W      = 3;
  localparam int STEP_W     = 3;
  localparam int CHAN_W     = 6;
  localparam int IDX_W      = 6;
  localparam int POS_W      = 7;
  localparam int SPAN_W     = 8;
  localparam int PLANE_W    = 13;
  localparam int BASE_W     = 18;
  localparam int SUM_W      = 19;
  localparam int ADDR_IN_W  = 12;
  localparam int PIXEL_W    = 32;
  localparam int VALUE_W    = 32;
  localparam int IN_TDATA_W = 48;
  localparam int OUT_USER_W = 3;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // largest image dimension
  localparam logic [DIM_W-1:0] DIM_LIMIT = 7'd64;

  // register reset values
  localparam logic [DIM_W-1:0]  RST_CHANNEL_COUNT = 7'd1;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 7'd8;
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 7'd8;
  localparam logic [KERN_W-1:0] RST_KERNEL_HEIGHT = 4'd3;
  localparam logic [KERN_W-1:0] RST_KERNEL_WIDTH  = 4'd3;
  localparam logic [PAD_W-1:0]  RST_PADDING       = 3'd0;
  localparam logic [STEP_W-1:0] RST_STEP_SIZE     = 3'd1;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_KERNEL_WIDTH  = 3'd4,
    REG_PADDING       = 3'd5,
    REG_STEP_SIZE     = 3'd6
  } reg_index_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_ADDR = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [DIM_W-1:0]  channel_count;
    logic [DIM_W-1:0]  image_height;
    logic [DIM_W-1:0]  image_width;
    logic [KERN_W-1:0] kernel_height;
    logic [KERN_W-1:0] kernel_width;
    logic [PAD_W-1:0]  padding;
    logic [STEP_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SUM_W-1:0]   addr;
    logic [PIXEL_W-1:0] pixel;
    logic               pad;
    logic               last;
    status_t            status;
  } cmd_t;

endpackage

>>> sv/im2col_cfg.sv
// configuration register file behind the apb-style port
module im2col_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [im2col_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [im2col_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready,
  output im2col_pkg::cfg_t                   cfg,
  output logic                               restart
);
  import im2col_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[CFG_ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= RST_CHANNEL_COUNT;
      cfg.image_height  <= RST_IMAGE_HEIGHT;
      cfg.image_width   <= RST_IMAGE_WIDTH;
      cfg.kernel_height <= RST_KERNEL_HEIGHT;
      cfg.kernel_width  <= RST_KERNEL_WIDTH;
      cfg.padding       <= RST_PADDING;
      cfg.step_size     <= RST_STEP_SIZE;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[DIM_W-1:0];
        REG_KERNEL_HEIGHT: cfg.kernel_height <= pwdata[KERN_W-1:0];
        REG_KERNEL_WIDTH:  cfg.kernel_width  <= pwdata[KERN_W-1:0];
        REG_PADDING:       cfg.padding       <= pwdata[PAD_W-1:0];
        REG_STEP_SIZE:     cfg.step_size     <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // any write to a real register restarts the walk
  always_comb begin
    restart = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_CHANNEL_COUNT, REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_KERNEL_HEIGHT,
        REG_KERNEL_WIDTH, REG_PADDING, REG_STEP_SIZE: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_CHANNEL_COUNT: prdata = CFG_DATA_W'(cfg.channel_count);
      REG_IMAGE_HEIGHT:  prdata = CFG_DATA_W'(cfg.image_height);
      REG_IMAGE_WIDTH:   prdata = CFG_DATA_W'(cfg.image_width);
      REG_KERNEL_HEIGHT: prdata = CFG_DATA_W'(cfg.kernel_height);
      REG_KERNEL_WIDTH:  prdata = CFG_DATA_W'(cfg.kernel_width);
      REG_PADDING:       prdata = CFG_DATA_W'(cfg.padding);
      REG_STEP_SIZE:     prdata = CFG_DATA_W'(cfg.step_size);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> sv/im2col_front.sv
// front end: accepts requests, walks the window counters, builds store commands
module im2col_front #(
  parameter int IMAGE_WORDS = im2col_pkg::IMAGE_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  im2col_pkg::cfg_t                   cfg,
  input  logic                               restart,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [im2col_pkg::IN_TDATA_W-1:0]  in_data,
  input  logic                               in_op,
  input  logic                               queue_full,
  output logic                               push,
  output im2col_pkg::cmd_t                   cmd
);
  import im2col_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : v;
  endfunction

  // walk state: output positions are kept pre-multiplied by the stride
  logic [CHAN_W-1:0] channel;
  logic [KERN_W-1:0] krow, kcol;
  logic [POS_W-1:0]  pos_row, pos_col;
  logic [BASE_W-1:0] ch_base;

  op_t                op;
  logic [ADDR_IN_W-1:0] in_addr;
  logic [PIXEL_W-1:0] in_pixel;
  logic [DIM_W-1:0]   chans, h, w;
  logic [SPAN_W-1:0]  span_h, span_w, d_h, d_w;
  logic               empty;
  logic [SPAN_W-1:0]  row_raw, col_raw, row_idx, col_idx;
  logic               is_pad;
  logic [PLANE_W-1:0] plane, row_offs;
  logic [SUM_W-1:0]   addr_sum;
  logic               read_in_range, load_in_range;
  logic [SPAN_W-1:0]  row_step, col_step;
  logic [KERN_W:0]    kr_next, kc_next;
  logic [DIM_W-1:0]   ch_next;
  logic               col_wrap, row_wrap, kc_wrap, kr_wrap, ch_wrap;
  logic               advance;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // request fields
  assign op       = op_t'(in_op);
  assign in_addr  = in_data[ADDR_IN_W-1:0];
  assign in_pixel = in_data[ADDR_IN_W +: PIXEL_W];

  // geometry
  always_comb begin
    chans  = clamp_dim(cfg.channel_count);
    h      = clamp_dim(cfg.image_height);
    w      = clamp_dim(cfg.image_width);
    span_h = SPAN_W'(h) + SPAN_W'({cfg.padding, 1'b0});
    span_w = SPAN_W'(w) + SPAN_W'({cfg.padding, 1'b0});
    d_h    = span_h - SPAN_W'(cfg.kernel_height);
    d_w    = span_w - SPAN_W'(cfg.kernel_width);
    empty  = (chans == '0) || (h == '0) || (w == '0) || (cfg.kernel_height == '0) ||
             (cfg.kernel_width == '0) || (cfg.step_size == '0) ||
             (span_h < SPAN_W'(cfg.kernel_height)) || (span_w < SPAN_W'(cfg.kernel_width));
    plane  = PLANE_W'(h) * PLANE_W'(w);
  end

  // pixel position and store address of the current element
  always_comb begin
    row_raw  = SPAN_W'(pos_row) + SPAN_W'(krow);
    col_raw  = SPAN_W'(pos_col) + SPAN_W'(kcol);
    row_idx  = row_raw - SPAN_W'(cfg.padding);
    col_idx  = col_raw - SPAN_W'(cfg.padding);
    is_pad   = (row_raw < SPAN_W'(cfg.padding)) || (col_raw < SPAN_W'(cfg.padding)) ||
               (row_idx >= SPAN_W'(h)) || (col_idx >= SPAN_W'(w));
    row_offs = PLANE_W'(row_idx[IDX_W-1:0]) * PLANE_W'(w);
    addr_sum = SUM_W'(ch_base) + SUM_W'(row_offs) + SUM_W'(col_idx[IDX_W-1:0]);
    read_in_range = addr_sum < SUM_W'(IMAGE_WORDS);
    load_in_range = SUM_W'(in_addr) < SUM_W'(IMAGE_WORDS);
  end

  // wrap conditions of the nested counters
  always_comb begin
    col_step = SPAN_W'(pos_col) + SPAN_W'(cfg.step_size);
    row_step = SPAN_W'(pos_row) + SPAN_W'(cfg.step_size);
    kc_next  = (KERN_W + 1)'(kcol) + (KERN_W + 1)'(1);
    kr_next  = (KERN_W + 1)'(krow) + (KERN_W + 1)'(1);
    ch_next  = DIM_W'(channel) + DIM_W'(1);
    col_wrap = col_step > d_w;
    row_wrap = row_step > d_h;
    kc_wrap  = kc_next >= (KERN_W + 1)'(cfg.kernel_width);
    kr_wrap  = kr_next >= (KERN_W + 1)'(cfg.kernel_height);
    ch_wrap  = ch_next >= chans;
    advance  = push && (op == OP_EMIT) && !empty;
  end

  // command for the back end
  always_comb begin
    cmd.kind   = CMD_NONE;
    cmd.addr   = SUM_W'(in_addr);
    cmd.pixel  = in_pixel;
    cmd.pad    = 1'b0;
    cmd.last   = 1'b0;
    cmd.status = STATUS_OK;
    priority if (op == OP_LOAD) begin
      if (load_in_range) cmd.kind = CMD_WRITE;
      else cmd.status = STATUS_BAD_ADDR;
    end else if (empty) begin
      cmd.status = STATUS_EMPTY;
    end else begin
      cmd.addr = addr_sum;
      cmd.pad  = is_pad;
      cmd.last = col_wrap && row_wrap && kc_wrap && kr_wrap && ch_wrap;
      if (!is_pad && read_in_range) cmd.kind = CMD_READ;
    end
  end

  // walk counters: output column innermost, channel outermost
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      channel <= '0;
      krow    <= '0;
      kcol    <= '0;
      pos_row <= '0;
      pos_col <= '0;
      ch_base <= '0;
    end else if (advance) begin
      if (!col_wrap) begin
        pos_col <= col_step[POS_W-1:0];
      end else begin
        pos_col <= '0;
        if (!row_wrap) begin
          pos_row <= row_step[POS_W-1:0];
        end else begin
          pos_row <= '0;
          if (!kc_wrap) begin
            kcol <= kc_next[KERN_W-1:0];
          end else begin
            kcol <= '0;
            if (!kr_wrap) begin
              krow <= kr_next[KERN_W-1:0];
            end else begin
              krow <= '0;
              if (!ch_wrap) begin
                channel <= ch_next[CHAN_W-1:0];
                ch_base <= ch_base + BASE_W'(plane);
              end else begin
                channel <= '0;
                ch_base <= '0;
              end
            end
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_last_restarts_walk: assert property (@(posedge clk) disable iff (rst)
    push && cmd.last |=> (channel == '0) && (krow == '0) && (kcol == '0) &&
                         (pos_row == '0) && (pos_col == '0) && (ch_base == '0))
    else $error("walk did not restart after the last element");
  a_read_is_inside: assert property (@(posedge clk) disable iff (rst)
    push && (cmd.kind == CMD_READ) |-> !cmd.pad && (cmd.status == STATUS_OK) &&
                                      (op == OP_EMIT))
    else $error("store read issued for a padding or non-emit request");
  a_walk_holds_when_empty: assert property (@(posedge clk) disable iff (rst || restart)
    push && (cmd.status == STATUS_EMPTY) |=> $stable(pos_col) && $stable(channel))
    else $error("walk moved on an empty geometry");
`endif

endmodule

>>> sv/im2col_queue.sv
// short command queue between the front and back ends
module im2col_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  im2col_pkg::cmd_t  push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output im2col_pkg::cmd_t  head
);
  import im2col_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      priority if (push && !pop) count <= count + (PTR_W + 1)'(1);
      else if (pop && !push)     count <= count - (PTR_W + 1)'(1);
      else                       count <= count;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (PTR_W + 1)'(1))
    else $error("fill count lost a push");
`endif

endmodule

>>> sv/im2col_back.sv
// back end: image store, read stage and output register
module im2col_back #(
  parameter int DATA_WIDTH  = im2col_pkg::DATA_WIDTH_DEF,
  parameter int IMAGE_WORDS = im2col_pkg::IMAGE_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  im2col_pkg::cmd_t                   head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [im2col_pkg::VALUE_W-1:0]     out_value,
  output logic                               out_pad,
  output logic                               out_last,
  output im2col_pkg::status_t                out_status
);
  import im2col_pkg::*;

  localparam int ADDR_W = $clog2(IMAGE_WORDS);

  logic [DATA_WIDTH-1:0] store [IMAGE_WORDS];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [ADDR_W-1:0]     idx;
  logic                  s1_valid, s1_adv;
  cmd_t                  s1_cmd;
  logic [VALUE_W-1:0]    s1_value;

  // handshake between queue, read stage and output register
  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign pop    = head_valid && (!s1_valid || s1_adv);
  assign idx    = head.addr[ADDR_W-1:0];

  // single-port image store
  always_ff @(posedge clk) begin
    if (pop && (head.kind == CMD_WRITE)) store[idx] <= DATA_WIDTH'(head.pixel);
    if (pop && (head.kind == CMD_READ))  rd_data <= store[idx];
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1_cmd <= head;
  end

  // loads, padding and unread elements give zero
  always_comb begin
    unique case (s1_cmd.kind)
      CMD_READ: s1_value = VALUE_W'(rd_data);
      default:  s1_value = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value  <= s1_value;
      out_pad    <= s1_cmd.pad;
      out_last   <= s1_cmd.last;
      out_status <= s1_cmd.status;
    end
  end

`ifndef SYNTHESIS
  a_pad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pad |-> (out_value == '0) && (out_status == STATUS_OK))
    else $error("padding element carries data");
  a_error_is_bare: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != STATUS_OK) |-> (out_value == '0) && !out_last && !out_pad)
    else $error("flagged result carries element fields");
  a_stage_moves_on: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !pop |=> !s1_valid)
    else $error("read stage kept a request it passed on");
`endif

endmodule

>>> sv/im2col_patch_unroller.sv
// im2col patch unroller: image store plus column-matrix walker, top level
//
// Requests arrive on the s_ stream: s_tuser selects a load (0) or an emit (1).
// A load writes s_tdata pixel_value at image_address of the store; an emit
// returns the next column-matrix element, channel outermost, output column
// innermost. Every request gives exactly one result on the m_ stream, in order.
// m_tlast marks the final element, after which the walk starts over.
// Timing: one request per cycle sustained while the receiver takes results. A result
// passes the command queue, then the read stage with the registered read of the
// single-port image store, which sets the rate, then the output register.
// Receiver stalls: the output register holds its result, the read stage and a
// four-entry queue absorb further requests, then s_tready drops.
// Reset: registers take their default geometry (1 channel, 8x8 image, 3x3
// kernel, no padding, stride 1), the walk goes to its start, the queue empties.
// The store is not cleared; load every word before it is read.
// Registers are written over the apb port at 4*index, by the user only while idle
// (not enforced by the block); any write to a real register restarts the walk.
module im2col_patch_unroller #(
  parameter int DATA_WIDTH  = im2col_pkg::DATA_WIDTH_DEF,
  parameter int IMAGE_WORDS = im2col_pkg::IMAGE_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // apb configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [im2col_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [im2col_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [im2col_pkg::IN_TDATA_W-1:0]  s_tdata,  // image_address, pixel_value
  input  logic                               s_tuser,  // operation
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [im2col_pkg::VALUE_W-1:0]     m_tdata,  // column_value
  output logic [im2col_pkg::OUT_USER_W-1:0]  m_tuser,  // is_padding, status
  output logic                               m_tlast   // last_element
);
  import im2col_pkg::*;

  cfg_t    cfg;
  logic    restart;
  logic    push, queue_full, pop, head_valid;
  cmd_t    push_cmd, head;
  logic    out_pad;
  status_t out_status;

  // configuration registers
  im2col_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // request classification and walk
  im2col_front #(
    .IMAGE_WORDS (IMAGE_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .restart    (restart),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_op      (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // decoupling queue
  im2col_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // store access and result delivery
  im2col_back #(
    .DATA_WIDTH  (DATA_WIDTH),
    .IMAGE_WORDS (IMAGE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (m_tdata),
    .out_pad    (out_pad),
    .out_last   (m_tlast),
    .out_status (out_status)
  );

  assign m_tuser = {out_status, out_pad};

endmodule

>>> sim/testbench.sv
// self-checking testbench for the im2col patch unroller: stream requests, apb setup, column checks
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import im2col_pkg::*;

  localparam int STORE_WORDS = IMAGE_WORDS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 800;
  localparam int PRINT_LIMIT = 40;
  // register slot past the end of the register list
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               pad;
    logic               last;
    status_t            status;
  } column_result_t;

  // clock, reset and block inputs, all known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;   // image_address, pixel_value
  logic                  s_tuser = 1'b0; // operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [VALUE_W-1:0]    m_tdata;        // column_value
  logic [OUT_USER_W-1:0] m_tuser;        // is_padding, status
  logic                  m_tlast;        // last_element

  im2col_patch_unroller dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // shadow of the block: registers, walk position and image store
  int chan_cfg = 1, height_cfg = 8, width_cfg = 8;
  int kern_h_cfg = 3, kern_w_cfg = 3, pad_cfg = 0, stride_cfg = 1;
  int walk_chan, walk_krow, walk_kcol, walk_orow, walk_ocol;
  logic [PIXEL_W-1:0] store_mirror [STORE_WORDS];
  bit                 word_written [STORE_WORDS];

  column_result_t column_queue [$];
  int  mismatch_count;
  int  items_sent;
  int  cycle_count;
  int  stall_left;
  int  stall_roll;
  bit  idle_enabled;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycle_count);
    mismatch_count++;
  endtask

  // geometry model
  function automatic int clamp_dim(int v);
    return (v > 64) ? 64 : v;
  endfunction

  function automatic int axis_count(int size, int kern);
    int span;
    span = size + 2 * pad_cfg;
    if (size == 0 || kern == 0 || stride_cfg == 0 || span < kern) return 0;
    return (span - kern) / stride_cfg + 1;
  endfunction

  function automatic void walk_geometry(output int chans, output int rows_out,
                                        output int cols_out, output int img_h,
                                        output int img_w);
    chans    = clamp_dim(chan_cfg);
    img_h    = clamp_dim(height_cfg);
    img_w    = clamp_dim(width_cfg);
    rows_out = axis_count(img_h, kern_h_cfg);
    cols_out = axis_count(img_w, kern_w_cfg);
  endfunction

  function automatic int walk_length();
    int chans, oh, ow, h, w;
    walk_geometry(chans, oh, ow, h, w);
    if (chans == 0 || oh == 0 || ow == 0) return 0;
    return chans * kern_h_cfg * kern_w_cfg * oh * ow;
  endfunction

  // where the next emit reads from
  function automatic void locate_emit(output bit empty, output bit outside,
                                      output int word_addr);
    int chans, oh, ow, h, w, row, col;
    walk_geometry(chans, oh, ow, h, w);
    empty = (chans == 0 || oh == 0 || ow == 0);
    outside = 1'b0;
    word_addr = -1;
    if (empty) return;
    row = walk_orow * stride_cfg + walk_krow - pad_cfg;
    col = walk_ocol * stride_cfg + walk_kcol - pad_cfg;
    if (row < 0 || row >= h || col < 0 || col >= w) outside = 1'b1;
    else word_addr = (walk_chan * h + row) * w + col;
  endfunction

  // step the walk, output column innermost; returns the final-element mark
  function automatic bit advance_walk();
    int chans, oh, ow, h, w;
    walk_geometry(chans, oh, ow, h, w);
    walk_ocol++;
    if (walk_ocol < ow) return 1'b0;
    walk_ocol = 0;
    walk_orow++;
    if (walk_orow < oh) return 1'b0;
    walk_orow = 0;
    walk_kcol++;
    if (walk_kcol < kern_w_cfg) return 1'b0;
    walk_kcol = 0;
    walk_krow++;
    if (walk_krow < kern_h_cfg) return 1'b0;
    walk_krow = 0;
    walk_chan++;
    if (walk_chan < chans) return 1'b0;
    walk_chan = 0;
    return 1'b1;
  endfunction

  function automatic void restart_walk();
    walk_chan = 0;
    walk_krow = 0;
    walk_kcol = 0;
    walk_orow = 0;
    walk_ocol = 0;
  endfunction

  function automatic logic [31:0] field_mask(logic [2:0] idx);
    case (idx)
      REG_CHANNEL_COUNT, REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH: return 32'h7F;
      REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH: return 32'hF;
      REG_PADDING, REG_STEP_SIZE: return 32'h7;
      default: return 32'h0;
    endcase
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] word);
    case (idx)
      REG_CHANNEL_COUNT: chan_cfg   = int'(word & 32'h7F);
      REG_IMAGE_HEIGHT:  height_cfg = int'(word & 32'h7F);
      REG_IMAGE_WIDTH:   width_cfg  = int'(word & 32'h7F);
      REG_KERNEL_HEIGHT: kern_h_cfg = int'(word & 32'hF);
      REG_KERNEL_WIDTH:  kern_w_cfg = int'(word & 32'hF);
      REG_PADDING:       pad_cfg    = int'(word & 32'h7);
      REG_STEP_SIZE:     stride_cfg = int'(word & 32'h7);
      default: return;
    endcase
    restart_walk();
  endfunction

  // expected result of one accepted request
  function automatic column_result_t predict_column(op_t op, logic [ADDR_IN_W-1:0] addr,
                                                    logic [PIXEL_W-1:0] pix);
    column_result_t res;
    bit empty, outside;
    int word_addr;
    res.value = '0;
    res.pad = 1'b0;
    res.last = 1'b0;
    res.status = STATUS_OK;
    if (op == OP_LOAD) begin
      if (int'(addr) >= STORE_WORDS) begin
        res.status = STATUS_BAD_ADDR;
      end else begin
        store_mirror[addr] = pix;
        word_written[addr] = 1'b1;
      end
      return res;
    end
    locate_emit(empty, outside, word_addr);
    if (empty) begin
      res.status = STATUS_EMPTY;
      return res;
    end
    if (outside) res.pad = 1'b1;
    else if (word_addr < STORE_WORDS) res.value = store_mirror[word_addr];
    res.last = advance_walk();
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one request on the input stream, predicted when accepted
  task automatic send_request(op_t op, logic [ADDR_IN_W-1:0] addr, logic [PIXEL_W-1:0] pix);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, pix, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    column_queue.push_back(predict_column(op, addr, pix));
    items_sent++;
  endtask

  // emit, first loading the word it reads if that word was never written
  task automatic send_emit();
    bit empty, outside;
    int word_addr;
    locate_emit(empty, outside, word_addr);
    if (!empty && !outside && word_addr < STORE_WORDS && !word_written[word_addr])
      send_request(OP_LOAD, word_addr[ADDR_IN_W-1:0], $urandom);
    send_request(OP_EMIT, ADDR_IN_W'($urandom), $urandom);
  endtask

  task automatic send_emits(int count);
    repeat (count) send_emit();
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (column_queue.size() != 0) @(posedge clk);
  endtask

  task automatic apb_cycle(bit wr, logic [2:0] idx, logic [31:0] word,
                           output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register write while idle, unused upper bits randomized, then read back if it has a field
  task automatic write_register(logic [2:0] idx, int value);
    logic [31:0] mask, word, readback;
    mask = field_mask(idx);
    wait_results_drained();
    repeat (4) @(posedge clk);
    word = ($urandom & ~mask) | (value & mask);
    apb_cycle(1'b1, idx, word, readback);
    apply_register(idx, word);
    if (mask != 0) begin
      apb_cycle(1'b0, idx, '0, readback);
      if (readback !== (word & mask)) report_mismatch("register readback", word & mask, readback);
    end
  endtask

  task automatic write_geometry(int ch, int h, int w, int kh, int kw, int pad, int stride);
    write_register(REG_CHANNEL_COUNT, ch);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_KERNEL_HEIGHT, kh);
    write_register(REG_KERNEL_WIDTH, kw);
    write_register(REG_PADDING, pad);
    write_register(REG_STEP_SIZE, stride);
  endtask

  // result checker
  always @(posedge clk) begin
    column_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (column_queue.size() == 0) begin
        report_mismatch("result with no request waiting", '0, m_tdata);
      end else begin
        want = column_queue.pop_front();
        if (m_tdata !== want.value) report_mismatch("column_value", want.value, m_tdata);
        if (m_tuser[0] !== want.pad) report_mismatch("is_padding", want.pad, m_tuser[0]);
        if (m_tuser[2:1] !== want.status) report_mismatch("status", want.status, m_tuser[2:1]);
        if (m_tlast !== want.last) report_mismatch("last_element", want.last, m_tlast);
      end
    end
  end

  // receiver backpressure, mostly short stalls and a few long ones
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (idle_enabled) begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 10) stall_left = $urandom_range(1, 3);
        else if (stall_roll < 12) stall_left = $urandom_range(15, 40);
      end
    end
  end

  // reset geometry, store extremes
  task automatic test_reset_defaults();
    send_request(OP_LOAD, 12'hFFF, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 12'h000, 32'h0000_0000);
    send_emits(3);
  endtask

  // one pixel under a 3x3 window with a one-pixel border: full walk and wrap
  task automatic test_single_pixel_walk();
    write_geometry(1, 1, 1, 3, 3, 1, 1);
    send_emits(11);
  endtask

  // a write to the spare slot keeps the walk, a real write restarts it
  task automatic test_walk_restart();
    write_geometry(1, 3, 3, 1, 1, 0, 1);
    send_emits(4);
    write_register(REG_SPARE, $urandom);
    send_emits(2);
    write_register(REG_STEP_SIZE, 1);
    send_emits(3);
  endtask

  // zero registers and a window larger than the padded image
  task automatic test_empty_geometry();
    write_geometry(2, 4, 4, 2, 2, 0, 1);
    send_emit();
    write_register(REG_CHANNEL_COUNT, 0);
    send_emit();
    write_register(REG_CHANNEL_COUNT, 2);
    write_register(REG_IMAGE_HEIGHT, 0);
    send_emit();
    write_register(REG_IMAGE_HEIGHT, 4);
    write_register(REG_IMAGE_WIDTH, 0);
    send_emit();
    write_register(REG_IMAGE_WIDTH, 4);
    write_register(REG_KERNEL_HEIGHT, 0);
    send_emit();
    write_register(REG_KERNEL_HEIGHT, 2);
    write_register(REG_KERNEL_WIDTH, 0);
    send_emit();
    write_register(REG_KERNEL_WIDTH, 2);
    write_register(REG_STEP_SIZE, 0);
    send_emit();
    write_geometry(1, 2, 5, 3, 3, 0, 1);
    send_emit();
    write_geometry(1, 5, 2, 3, 3, 0, 1);
    send_emit();
  endtask

  // largest window, border and stride; oversized channel count
  task automatic test_window_extremes();
    write_geometry(127, 1, 1, 15, 15, 7, 7);
    send_emits(12);
  endtask

  // 64x64 image, oversized registers: the second channel lies past the store
  task automatic test_store_overrun();
    write_geometry(64, 127, 100, 1, 1, 0, 7);
    send_emits(112);
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(64, 127);
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_kernel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 8) return 15;
    return $urandom_range(1, 4);
  endfunction

  // random geometries, walks with random loads mixed in
  task automatic test_random_phases();
    int target, phase, requests, r;
    target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < target) begin
      phase++;
      idle_enabled = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 5) write_register(REG_CHANNEL_COUNT, 0);
        else if (r < 10) write_register(REG_CHANNEL_COUNT, $urandom_range(64, 127));
        else write_register(REG_CHANNEL_COUNT, $urandom_range(1, 3));
      end
      if ($urandom_range(0, 2) != 0) write_register(REG_IMAGE_HEIGHT, pick_dim());
      if ($urandom_range(0, 2) != 0) write_register(REG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(0, 2) != 0) write_register(REG_KERNEL_HEIGHT, pick_kernel());
      if ($urandom_range(0, 2) != 0) write_register(REG_KERNEL_WIDTH, pick_kernel());
      if ($urandom_range(0, 2) != 0)
        write_register(REG_PADDING, ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 2));
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 4) write_register(REG_STEP_SIZE, 0);
        else if (r < 10) write_register(REG_STEP_SIZE, 7);
        else write_register(REG_STEP_SIZE, $urandom_range(1, 3));
      end
      requests = walk_length();
      if (requests == 0) requests = $urandom_range(3, 8);
      requests += $urandom_range(0, 12);
      if (requests > 200) requests = 200;
      for (int i = 0; i < requests; i++) begin
        // hold off once until the block has delivered everything
        if (phase == 3 && i == requests / 2) wait_results_drained();
        if ($urandom_range(0, 99) < 12)
          send_request(OP_LOAD, ADDR_IN_W'($urandom), $urandom);
        else
          send_emit();
      end
    end
  endtask

  initial begin
    idle_enabled = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_single_pixel_walk();
    test_walk_restart();
    test_empty_geometry();
    test_window_extremes();
    test_store_overrun();
    test_random_phases();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/im2col_pkg.sv
sv/im2col_cfg.sv
sv/im2col_front.sv
sv/im2col_queue.sv
sv/im2col_back.sv
sv/im2col_patch_unroller.sv
sim/testbench.sv
